// ----- design/tim8_pkg.sv -----
// Shared types, constants and helpers for the 8bpp palette image decoder.
package tim8_pkg;

	// Sizing
	localparam int MAX_PALETTES        = 8;
	localparam int PALETTE_ENTRIES     = 256;
	localparam int COLUMNS_PER_PALETTE = 128;
	localparam int PALETTE_BYTES       = 2 * PALETTE_ENTRIES;
	localparam int PAL_DEPTH           = MAX_PALETTES * PALETTE_ENTRIES;
	localparam int PAL_ADDR_W          = $clog2(PAL_DEPTH);
	localparam int PAL_W               = 15;
	localparam int SEL_W               = $clog2(MAX_PALETTES + 1);
	localparam int POS_W               = $clog2(MAX_PALETTES * PALETTE_BYTES + 1);
	localparam int PAL_BYTE_SH         = $clog2(PALETTE_BYTES);
	localparam int CSUB_W = (COLUMNS_PER_PALETTE > 1) ? $clog2(COLUMNS_PER_PALETTE) : 1;
	localparam int COL_W               = 17;
	localparam int ROW_W               = 16;

	// Header byte offsets
	localparam logic [7:0]       MAGIC_LOW   = 8'h10;
	localparam logic [POS_W-1:0] MAGIC_LEN   = POS_W'(4);
	localparam logic [POS_W-1:0] MAGIC_LAST  = POS_W'(3);
	localparam logic [POS_W-1:0] MAGIC_FIRST = POS_W'(0);
	localparam logic [POS_W-1:0] CNT_LO_POS  = POS_W'(18);
	localparam logic [POS_W-1:0] CNT_HI_POS  = POS_W'(19);
	localparam logic [POS_W-1:0] WID_LO_POS  = POS_W'(8);
	localparam logic [POS_W-1:0] WID_HI_POS  = POS_W'(9);
	localparam logic [POS_W-1:0] HGT_LO_POS  = POS_W'(10);
	localparam logic [POS_W-1:0] HGT_HI_POS  = POS_W'(11);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_PALETTE,
		PH_IMAGE_HDR,
		PH_PIXELS,
		PH_HALTED
	} phase_t;

	typedef enum logic [1:0] {
		ST_PIXEL,
		ST_BAD_MAGIC,
		ST_TOO_MANY,
		ST_BAD_SEL
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} src_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		status_t    status;
		logic       last_pixel;
	} pix_item_t;

	// Palette memory access from the parser
	typedef struct packed {
		logic                  we;
		logic [PAL_ADDR_W-1:0] waddr;
		logic [PAL_W-1:0]      wdata;
		logic                  re;
		logic [PAL_ADDR_W-1:0] raddr;
	} mem_req_t;

	// Result tag that travels beside the memory read
	typedef struct packed {
		logic    valid;
		status_t status;
		logic    last_pixel;
	} res_tag_t;

	// 5-bit channel to 8 bits by replicating the top bits
	function automatic logic [7:0] expand5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

endpackage

// ----- design/tim8_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module tim8_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/tim8_parser.sv -----
// Byte-stream parser: header checks, palette writes and pixel lookups.
module tim8_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_ready,
	input  tim8_pkg::src_item_t src_item,
	input  logic                load_ok,
	output tim8_pkg::mem_req_t  mem_req,
	output tim8_pkg::res_tag_t  res_tag
);
	import tim8_pkg::*;

	phase_t               phase_q, phase_d;
	logic [POS_W-1:0]     pos_q, pos_d;
	logic                 magic_ok_q, magic_ok_d;
	logic [SEL_W-1:0]     count_q, count_d;
	logic [7:0]           hold_q, hold_d;
	logic [15:0]          width_q, width_d;
	logic [COL_W-1:0]     row_last_q, row_last_d;
	logic [ROW_W-1:0]     height_last_q, height_last_d;
	logic [COL_W-1:0]     col_q, col_d;
	logic [ROW_W-1:0]     row_q, row_d;
	logic [SEL_W-1:0]     sel_q, sel_d;
	logic [CSUB_W-1:0]    csub_q, csub_d;

	logic                 accept;
	phase_t               cur_phase;
	logic [POS_W-1:0]     cur_pos;
	logic [POS_W-1:0]     pos_inc;
	logic                 cur_magic_ok;
	logic                 byte_ok;
	logic [7:0]           b;
	logic [15:0]          word16;
	logic                 is_last;

	assign src_ready = load_ok;
	assign accept    = src_valid & load_ok;
	assign b         = src_item.data_byte;
	assign word16    = {b, hold_q};

	// file start restarts the parse on this very byte
	assign cur_phase    = src_item.file_start ? PH_HEADER : phase_q;
	assign cur_pos      = src_item.file_start ? '0 : pos_q;
	assign cur_magic_ok = src_item.file_start ? 1'b1 : magic_ok_q;
	assign pos_inc      = cur_pos + POS_W'(1);

	// parse state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			pos_q      <= '0;
			magic_ok_q <= 1'b1;
			count_q    <= '0;
		end else begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			magic_ok_q <= magic_ok_d;
			count_q    <= count_d;
		end
	end

	// fields and counters, always written before use
	always_ff @(posedge clk) begin
		hold_q        <= hold_d;
		width_q       <= width_d;
		row_last_q    <= row_last_d;
		height_last_q <= height_last_d;
		col_q         <= col_d;
		row_q         <= row_d;
		sel_q         <= sel_d;
		csub_q        <= csub_d;
	end

	// next state, memory requests and results
	always_comb begin
		phase_d       = phase_q;
		pos_d         = pos_q;
		magic_ok_d    = magic_ok_q;
		count_d       = count_q;
		hold_d        = hold_q;
		width_d       = width_q;
		row_last_d    = row_last_q;
		height_last_d = height_last_q;
		col_d         = col_q;
		row_d         = row_q;
		sel_d         = sel_q;
		csub_d        = csub_q;
		byte_ok       = 1'b0;
		is_last       = 1'b0;
		mem_req       = '0;
		mem_req.waddr = pos_q[PAL_ADDR_W:1];
		mem_req.wdata = {b[6:0], hold_q};
		mem_req.raddr = PAL_ADDR_W'({sel_q, b});
		res_tag       = '0;
		res_tag.status = ST_PIXEL;

		if (accept) begin
			phase_d    = cur_phase;
			pos_d      = cur_pos;
			magic_ok_d = cur_magic_ok;
			unique case (cur_phase)
				PH_HEADER: begin
					pos_d = pos_inc;
					if (cur_pos < MAGIC_LEN) begin
						byte_ok    = (cur_pos == MAGIC_FIRST) ? (b == MAGIC_LOW) : (b == 8'h00);
						magic_ok_d = cur_magic_ok & byte_ok;
						if (cur_pos == MAGIC_LAST && !(cur_magic_ok & byte_ok)) begin
							phase_d        = PH_HALTED;
							res_tag.valid  = 1'b1;
							res_tag.status = ST_BAD_MAGIC;
						end
					end else if (cur_pos == CNT_LO_POS) begin
						hold_d = b;
					end else if (cur_pos == CNT_HI_POS) begin
						if (word16 > 16'(MAX_PALETTES)) begin
							phase_d        = PH_HALTED;
							res_tag.valid  = 1'b1;
							res_tag.status = ST_TOO_MANY;
						end else begin
							count_d = word16[SEL_W-1:0];
							pos_d   = '0;
							phase_d = (word16 == 16'd0) ? PH_IMAGE_HDR : PH_PALETTE;
						end
					end
				end
				PH_PALETTE: begin
					// even byte is the low half, odd byte completes the entry
					if (!cur_pos[0])
						hold_d = b;
					else
						mem_req.we = 1'b1;
					pos_d = pos_inc;
					if (pos_inc == (POS_W'(count_q) << PAL_BYTE_SH)) begin
						pos_d   = '0;
						phase_d = PH_IMAGE_HDR;
					end
				end
				PH_IMAGE_HDR: begin
					pos_d = pos_inc;
					if (cur_pos == WID_LO_POS || cur_pos == HGT_LO_POS) begin
						hold_d = b;
					end else if (cur_pos == WID_HI_POS) begin
						width_d = word16;
					end else if (cur_pos == HGT_HI_POS) begin
						row_last_d    = {width_q, 1'b0} - COL_W'(1);
						height_last_d = word16 - 16'd1;
						pos_d         = '0;
						col_d         = '0;
						row_d         = '0;
						sel_d         = '0;
						csub_d        = '0;
						phase_d = (width_q == 16'd0 || word16 == 16'd0) ? PH_HALTED : PH_PIXELS;
					end
				end
				PH_PIXELS: begin
					if (sel_q >= count_q) begin
						phase_d        = PH_HALTED;
						res_tag.valid  = 1'b1;
						res_tag.status = ST_BAD_SEL;
					end else begin
						mem_req.re         = 1'b1;
						is_last            = (col_q == row_last_q) && (row_q == height_last_q);
						res_tag.valid      = 1'b1;
						res_tag.last_pixel = is_last;
						if (is_last) begin
							phase_d = PH_HALTED;
						end else if (col_q == row_last_q) begin
							col_d  = '0;
							row_d  = row_q + ROW_W'(1);
							sel_d  = '0;
							csub_d = '0;
						end else begin
							col_d = col_q + COL_W'(1);
							// palette selector steps every group of columns
							if (csub_q == CSUB_W'(COLUMNS_PER_PALETTE - 1)) begin
								csub_d = '0;
								sel_d  = sel_q + SEL_W'(1);
							end else begin
								csub_d = csub_q + CSUB_W'(1);
							end
						end
					end
				end
				PH_HALTED: begin
				end
				default: begin
					phase_d = PH_HALTED;
				end
			endcase
		end
	end

endmodule

// ----- design/tim8_out.sv -----
// Read-data stage and output register: color expansion and result handshake.
module tim8_out (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tim8_pkg::res_tag_t       res_tag,
	input  logic [tim8_pkg::PAL_W-1:0] rdata,
	output logic                     load_ok,
	output logic                     pix_valid,
	input  logic                     pix_ready,
	output tim8_pkg::pix_item_t      pix_item
);
	import tim8_pkg::*;

	logic      valid_s1;
	status_t   status_s1;
	logic      last_s1;
	logic      pix_valid_q;
	pix_item_t pix_item_q;
	logic      out_free;
	logic      move_s1;
	logic      is_pixel;

	assign out_free = !pix_valid_q || pix_ready;
	assign move_s1  = valid_s1 && out_free;
	assign load_ok  = !valid_s1 || out_free;
	assign is_pixel = (status_s1 == ST_PIXEL);

	// stage 1 tag waits beside the memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load_ok)
			valid_s1 <= res_tag.valid;
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			status_s1 <= res_tag.status;
			last_s1   <= res_tag.last_pixel;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pix_valid_q <= 1'b0;
		else if (move_s1)
			pix_valid_q <= 1'b1;
		else if (pix_ready)
			pix_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			pix_item_q.red        <= is_pixel ? expand5(rdata[14:10]) : 8'h00;
			pix_item_q.green      <= is_pixel ? expand5(rdata[9:5]) : 8'h00;
			pix_item_q.blue       <= is_pixel ? expand5(rdata[4:0]) : 8'h00;
			pix_item_q.status     <= status_s1;
			pix_item_q.last_pixel <= last_s1;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix_item  = pix_item_q;

endmodule

// ----- design/tim8_8bpp_palette_image_decoder_top.sv -----
// No logic here; the decoder's top level is in tim_8bpp_palette_image_decoder_top.sv.

// ----- design/tim_8bpp_palette_image_decoder_top.sv -----
// Top level of the 8bpp palette image decoder.
// Takes a texture file one byte per item (file_start on the first byte), checks the
// magic word and palette count, stores up to MAX_PALETTES palettes of 256 RGB555
// entries in a MAX_PALETTES*256 x 15 palette RAM, then turns each pixel index byte
// into an RGB888 result. Errors (bad magic, too many palettes, palette selector not
// below the count) give one result with color zero, after which bytes are dropped
// until the next file_start. The block takes one byte per clock while not stalled:
// each byte uses at most one palette RAM access (a write for palette bytes, a read for
// pixel bytes); its result is registered with its tag, then in the output register.
// The palette RAM is not cleared at reset; every entry a pixel can select has been
// written by its file before any pixel byte arrives.
module tim_8bpp_palette_image_decoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_ready,
	input  tim8_pkg::src_item_t src_item,
	output logic                pix_valid,
	input  logic                pix_ready,
	output tim8_pkg::pix_item_t pix_item
);
	import tim8_pkg::*;

	mem_req_t         mem_req;
	res_tag_t         res_tag;
	logic             load_ok;
	logic [PAL_W-1:0] rdata;

	// header, palette and pixel parse
	tim8_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.load_ok   (load_ok),
		.mem_req   (mem_req),
		.res_tag   (res_tag)
	);

	// palette store
	tim8_ram #(
		.WIDTH (PAL_W),
		.DEPTH (PAL_DEPTH)
	) u_pal_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	// color expansion and output handshake
	tim8_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_tag   (res_tag),
		.rdata     (rdata),
		.load_ok   (load_ok),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_item  (pix_item)
	);

endmodule

// ----- tb/tim_8bpp_palette_image_decoder_top_test.sv -----
// Testbench for the 8bpp palette image decoder: texture byte streams in, predicted pixels checked.
`timescale 1ns / 1ps

module tim_8bpp_palette_image_decoder_top_test;
	import tim8_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int DRAIN_CYCLES = 20;
	localparam int HEADER_LEN   = 20;
	localparam int IMG_HDR_LEN  = 12;
	localparam logic [31:0] TIM_MAGIC = {24'h0, MAGIC_LOW};

	typedef enum int {
		FK_GOOD,
		FK_BAD_MAGIC,
		FK_TOO_MANY,
		FK_EMPTY,
		FK_CUT,
		FK_NOISE
	} file_kind_t;

	// Tracks the parse of the byte stream and holds the pixels still owed by the block
	class tim_pixel_scoreboard;
		phase_t           phase;
		logic [15:0]      byte_pos;
		logic [7:0]       pal_count;
		logic [7:0]       low_hold;
		logic [31:0]      magic;
		logic [15:0]      width_units;
		logic [15:0]      height_rows;
		logic [16:0]      column;
		logic [15:0]      row;
		logic [PAL_W-1:0] palette_mem [PAL_DEPTH];
		pix_item_t        pending_pixels [$];
		int               fail_count;
		int               pixels_seen;

		function new();
			restart();
			fail_count  = 0;
			pixels_seen = 0;
		endfunction

		// Parser state at reset or at a file start; palette memory is kept
		function void restart();
			phase       = PH_HEADER;
			byte_pos    = '0;
			pal_count   = '0;
			low_hold    = '0;
			magic       = '0;
			width_units = '0;
			height_rows = '0;
			column      = '0;
			row         = '0;
		endfunction

		// Advance the parse by one byte; returns 1 when the byte yields a result
		function bit decode_byte(input src_item_t it, output pix_item_t res);
			int          p;
			int          cnt;
			int          pal;
			int          sel;
			int          row_len;
			logic [7:0]  b;
			logic [14:0] word;
			bit          is_last;
			res = '0;
			b = it.data_byte;
			if (it.file_start)
				restart();
			p = byte_pos;
			case (phase)
				PH_HEADER: begin
					byte_pos = 16'(p + 1);
					if (p < MAGIC_LEN) begin
						magic = magic | (32'(b) << (8 * p));
						if (p == MAGIC_LAST && magic != TIM_MAGIC) begin
							phase = PH_HALTED;
							res.status = ST_BAD_MAGIC;
							return 1;
						end
					end else if (p == CNT_LO_POS) begin
						low_hold = b;
					end else if (p == CNT_HI_POS) begin
						cnt = {b, low_hold};
						if (cnt > MAX_PALETTES) begin
							phase = PH_HALTED;
							res.status = ST_TOO_MANY;
							return 1;
						end
						pal_count = 8'(cnt);
						byte_pos = '0;
						if (cnt == 0)
							phase = PH_IMAGE_HDR;
						else
							phase = PH_PALETTE;
					end
				end
				PH_PALETTE: begin
					// two bytes per RGB555 word, bit 15 dropped
					if (p % 2 == 0) begin
						low_hold = b;
					end else begin
						pal = p / PALETTE_BYTES;
						if (pal < MAX_PALETTES)
							palette_mem[pal * PALETTE_ENTRIES + (p / 2) % PALETTE_ENTRIES] =
								PAL_W'({b, low_hold});
					end
					byte_pos = 16'(p + 1);
					if (p + 1 >= pal_count * PALETTE_BYTES) begin
						byte_pos = '0;
						phase = PH_IMAGE_HDR;
					end
				end
				PH_IMAGE_HDR: begin
					byte_pos = 16'(p + 1);
					if (p == WID_LO_POS || p == HGT_LO_POS) begin
						low_hold = b;
					end else if (p == WID_HI_POS) begin
						width_units = {b, low_hold};
					end else if (p == HGT_HI_POS) begin
						height_rows = {b, low_hold};
						byte_pos = '0;
						column = '0;
						row = '0;
						if (width_units == 0 || height_rows == 0)
							phase = PH_HALTED;
						else
							phase = PH_PIXELS;
					end
				end
				PH_PIXELS: begin
					row_len = 2 * width_units;
					sel = column / COLUMNS_PER_PALETTE;
					if (sel >= pal_count || sel >= MAX_PALETTES) begin
						phase = PH_HALTED;
						res.status = ST_BAD_SEL;
						return 1;
					end
					word = palette_mem[sel * PALETTE_ENTRIES + b];
					is_last = (column + 1 == row_len) && (row + 1 == height_rows);
					if (is_last) begin
						phase = PH_HALTED;
					end else if (column + 1 >= row_len) begin
						column = '0;
						row = row + 16'd1;
					end else begin
						column = column + 17'd1;
					end
					// 5-bit channels widened by repeating their top bits
					res.red = {word[14:10], word[14:12]};
					res.green = {word[9:5], word[9:7]};
					res.blue = {word[4:0], word[4:2]};
					res.status = ST_PIXEL;
					res.last_pixel = is_last;
					return 1;
				end
				default: ;
			endcase
			return 0;
		endfunction

		function void note_byte(input src_item_t it);
			pix_item_t res;
			if (decode_byte(it, res))
				pending_pixels.push_back(res);
		endfunction

		function void compare_field(input string field, input logic [7:0] want,
				input logic [7:0] got);
			if (got !== want) begin
				fail_count++;
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			end
		endfunction

		function void check_pixel(input pix_item_t got);
			pix_item_t want;
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				fail_count++;
				$display("%0t: result mismatch, expected none, got %p", $time, got);
				return;
			end
			want = pending_pixels.pop_front();
			compare_field("red", want.red, got.red);
			compare_field("green", want.green, got.green);
			compare_field("blue", want.blue, got.blue);
			compare_field("status", 8'(want.status), 8'(got.status));
			compare_field("last_pixel", 8'(want.last_pixel), 8'(got.last_pixel));
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_ready;
	src_item_t src_item;
	logic      pix_valid;
	logic      pix_ready = 1'b0;
	pix_item_t pix_item;

	tim_pixel_scoreboard sb = new;

	int bytes_sent  = 0;
	int file_budget = -1;
	int quiet_left  = 0;
	int stall_left  = 0;
	int run_left    = 0;
	int sink_roll;

	tim_8bpp_palette_image_decoder_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_item  (pix_item)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Handshake monitor: note accepted bytes, check accepted results
	always @(posedge clk) begin
		if (src_valid && src_ready) begin
			sb.note_byte(src_item);
			bytes_sent++;
		end
		if (pix_valid && pix_ready)
			sb.check_pixel(pix_item);
	end

	// Result side: short and long stalls, with stretches of steady ready
	always @(negedge clk) begin
		if (stall_left == 0 && run_left == 0) begin
			sink_roll = $urandom_range(0, 99);
			if (sink_roll < 3)
				stall_left = $urandom_range(10, 40);
			else if (sink_roll < 25)
				stall_left = $urandom_range(1, 3);
			else if (sink_roll < 30)
				run_left = $urandom_range(50, 200);
			else
				run_left = 1;
		end
		if (stall_left > 0) begin
			stall_left--;
			pix_ready <= 1'b0;
		end else begin
			run_left--;
			pix_ready <= 1'b1;
		end
	end

	// One byte item; called at a falling edge, returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] value, input logic mark);
		int gap;
		int roll;
		if (file_budget == 0)
			return;
		if (file_budget > 0)
			file_budget--;
		gap = 0;
		if (quiet_left > 0) begin
			quiet_left--;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 2)
				quiet_left = $urandom_range(50, 300);
			else if (roll < 5)
				gap = $urandom_range(8, 30);
			else if (roll < 30)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_item <= '{data_byte: value, file_start: mark};
		src_valid <= 1'b1;
		@(posedge clk);
		while (!src_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Whole texture file; trailing is the pixel byte count, or the bytes after an error
	task automatic send_file(input logic [31:0] magic, input logic [15:0] count,
			input logic [15:0] wu, input logic [15:0] ht, input int trailing, input logic mark);
		int         i;
		logic [7:0] b;
		for (i = 0; i < HEADER_LEN; i++) begin
			if (i == MAGIC_LEN && magic != TIM_MAGIC)
				break;
			if (i < MAGIC_LEN)
				b = magic[8 * i +: 8];
			else if (i == CNT_LO_POS)
				b = count[7:0];
			else if (i == CNT_HI_POS)
				b = count[15:8];
			else
				b = 8'($urandom);
			send_byte(b, mark && i == 0);
		end
		if (magic != TIM_MAGIC || count > MAX_PALETTES) begin
			repeat (trailing) send_byte(8'($urandom), 1'b0);
			return;
		end
		repeat (count * PALETTE_BYTES) send_byte(8'($urandom), 1'b0);
		for (i = 0; i < IMG_HDR_LEN; i++) begin
			if (i == WID_LO_POS)
				b = wu[7:0];
			else if (i == WID_HI_POS)
				b = wu[15:8];
			else if (i == HGT_LO_POS)
				b = ht[7:0];
			else if (i == HGT_HI_POS)
				b = ht[15:8];
			else
				b = 8'($urandom);
			send_byte(b, 1'b0);
		end
		repeat (trailing) send_byte(8'($urandom), 1'b0);
	endtask

	initial begin
		file_kind_t  kind;
		logic [31:0] magic;
		logic [15:0] count;
		logic [15:0] wu;
		logic [15:0] ht;
		int          pixels;
		int          span;
		int          roll;
		int          files_sent;
		logic        mark;

		arst_n = 1'b0;
		src_valid = 1'b0;
		src_item = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: unmarked stream after reset, all-zero magic, largest palette count
		send_file(32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 1, 1'b0);
		send_file(32'h0000_0000, 16'd0, 16'd0, 16'd0, 0, 1'b1);
		send_file(TIM_MAGIC, 16'hFFFF, 16'd0, 16'd0, 1, 1'b1);

		// Opening files: zero palettes, a complete small image, an empty image,
		// then every palette in use with the selector running past the last one
		send_file(TIM_MAGIC, 16'd0, 16'd2, 16'd1, 3, 1'b1);
		send_file(TIM_MAGIC, 16'd1, 16'd2, 16'd2, 10, 1'b1);
		send_file(TIM_MAGIC, 16'd0, 16'd0, 16'd5, 4, 1'b1);
		send_file(TIM_MAGIC, 16'(MAX_PALETTES), 16'(MAX_PALETTES * COLUMNS_PER_PALETTE / 2 + 1),
			16'd1, MAX_PALETTES * COLUMNS_PER_PALETTE + 2, 1'b1);

		// Random files, mostly well formed, some broken or plain noise
		files_sent = 0;
		while (bytes_sent < RANDOM_ITEMS || files_sent < 16 || sb.pixels_seen < 80) begin
			roll = $urandom_range(0, 99);
			if (roll < 40)
				kind = FK_GOOD;
			else if (roll < 55)
				kind = FK_BAD_MAGIC;
			else if (roll < 65)
				kind = FK_TOO_MANY;
			else if (roll < 75)
				kind = FK_EMPTY;
			else if (roll < 88)
				kind = FK_CUT;
			else
				kind = FK_NOISE;
			magic = TIM_MAGIC;
			count = '0;
			wu = 16'd1;
			ht = 16'd1;
			pixels = 0;
			mark = ($urandom_range(0, 19) != 0);
			file_budget = -1;
			case (kind)
				FK_GOOD, FK_CUT: begin
					roll = $urandom_range(0, 9);
					if (kind == FK_CUT)
						count = 16'($urandom_range(0, 1));
					else if (roll < 6)
						count = 16'd1;
					else if (roll < 8)
						count = 16'd2;
					else if (roll < 9)
						count = 16'd0;
					else
						count = 16'd3;
					span = count * COLUMNS_PER_PALETTE;
					roll = (kind == FK_CUT) ? 0 : $urandom_range(0, 3);
					if (roll < 2) begin
						// small image, with enough pixel bytes to reach its last pixel
						wu = 16'($urandom_range(1, 4));
						ht = 16'($urandom_range(1, 4));
						pixels = 2 * wu * ht + $urandom_range(0, 3);
					end else if (roll == 2) begin
						// rows exactly as wide as the stored palettes cover (one unit when none are stored)
						wu = (span == 0) ? 16'd1 : 16'(span / 2);
						ht = 16'($urandom_range(1, 2));
						pixels = 2 * wu * ht + $urandom_range(0, 2);
					end else begin
						// rows wider than the palettes: selector runs out on row 0
						if ($urandom_range(0, 1) == 1)
							wu = 16'(span / 2 + $urandom_range(1, 3));
						else
							wu = 16'($urandom_range(span / 2 + 1, 16'hFFFF));
						if ($urandom_range(0, 3) == 0)
							ht = 16'hFFFF;
						else
							ht = 16'($urandom_range(1, 16'hFFFF));
						pixels = span + 2;
					end
					if (kind == FK_GOOD && $urandom_range(0, 9) == 0)
						pixels = $urandom_range(0, pixels);
					if (kind == FK_CUT)
						file_budget = $urandom_range(1,
							HEADER_LEN + count * PALETTE_BYTES + IMG_HDR_LEN + pixels - 1);
				end
				FK_BAD_MAGIC: begin
					if ($urandom_range(0, 1) == 1)
						magic = TIM_MAGIC ^ (32'd1 << $urandom_range(0, 31));
					else
						magic = $urandom;
					if (magic == TIM_MAGIC)
						magic = ~magic;
					pixels = $urandom_range(0, 4);
				end
				FK_TOO_MANY: begin
					roll = $urandom_range(0, 2);
					if (roll == 0)
						count = 16'(MAX_PALETTES + 1);
					else if (roll == 1)
						count = 16'hFFFF;
					else
						count = 16'($urandom_range(MAX_PALETTES + 1, 16'hFFFF));
					pixels = $urandom_range(0, 4);
				end
				FK_EMPTY: begin
					count = ($urandom_range(0, 4) == 0) ? 16'd1 : 16'd0;
					roll = $urandom_range(0, 2);
					wu = (roll == 1) ? 16'($urandom_range(1, 16'hFFFF)) : 16'd0;
					ht = (roll == 0) ? 16'($urandom_range(1, 16'hFFFF)) : 16'd0;
					pixels = $urandom_range(1, 6);
				end
				default: ;
			endcase
			if (kind == FK_NOISE)
				repeat ($urandom_range(1, 12))
					send_byte(8'($urandom), $urandom_range(0, 3) == 0);
			else
				send_file(magic, count, wu, ht, pixels, mark);
			file_budget = -1;
			files_sent++;
		end
		src_valid <= 1'b0;

		// Drain the owed pixels, then give late extras time to show
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
